// File: hw/rtl/local_magnitude_from_amplitude_core_defines.svh
// Assertion helpers for the RTL file that carries concurrent checks.
`ifndef LOCAL_MAGNITUDE_FROM_AMPLITUDE_CORE_DEFINES_SVH
`define LOCAL_MAGNITUDE_FROM_AMPLITUDE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lmfa_pkg.sv
`default_nettype none

package lmfa_pkg;

  // Field widths.
  localparam int AMP_W      = 44;
  localparam int DEG_W      = 24;
  localparam int SNR_W      = 24;
  localparam int CFG_W      = 24;
  localparam int MAG_W      = 22;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 3;

  // Datapath widths.
  localparam int LEAD_W    = 6;
  localparam int FRAC_W    = 43;
  localparam int LG2_W     = 31;
  localparam int L2_W      = 37;
  localparam int LG_W      = 37;
  localparam int LOG10_2_W = 27;
  localparam int ACC_W     = 41;
  localparam int X_W       = 24;
  localparam int PKM_W     = 48;
  localparam int TOT_W     = 48;

  // Register stages from the input register to the result register.
  localparam int PIPE_DEPTH = 16;

  localparam int unsigned LOG_TAB_ENTRIES_DFLT = 256;

  typedef logic [63:0] u64_t;

  localparam u64_t Q30_ONE = 64'd1 << 30;
  localparam logic [LG2_W-1:0] LG2_ONE = 31'd1 << 30;
  localparam logic [LOG10_2_W-1:0] LOG10_2_Q28 = 27'd80807124;

  localparam logic [CFG_W-1:0] MIN_SNR_RST    = 24'd512;
  localparam logic [CFG_W-1:0] KM_PER_DEG_RST = 24'd7287276;

  // Distance in km, Q.32, up to which the quartic correction applies.
  localparam logic [PKM_W-1:0] NEAR_LIMIT = 48'd200 << 32;

  // Horner start values and per-step addends for both distance ranges.
  localparam logic signed [ACC_W-1:0] ACC0_NEAR = 41'sd26332727165;
  localparam logic signed [ACC_W-1:0] ACC0_FAR  = -41'sd429665021729;
  localparam logic signed [ACC_W-1:0] C_NEAR [4] = '{
    -41'sd61068810947, 41'sd49961808366, -41'sd17784600579, -41'sd1200443359
  };
  localparam logic signed [ACC_W-1:0] C_FAR [4] = '{
    41'sd0, 41'sd0, 41'sd9015995348, 41'sd35522399
  };
  // The far range only runs the last two Horner steps.
  localparam logic [3:0] FAR_ON = 4'b1100;

  typedef enum logic [0:0] {
    REG_MIN_SNR    = 1'b0,
    REG_KM_PER_DEG = 1'b1
  } cfg_reg_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_AMP_RANGE = 2'd1,
    ST_SNR_LOW   = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [X_W-1:0]          x;
    logic                    is_near;
  } poly_t;

  typedef struct packed {
    logic amp_zero;
    logic snr_low;
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    status_t          status;
    logic             treat_as_valid;
  } res_t;

  // log2(x0 / 2^30) in Q.30 by repeated truncating squaring; elaboration only.
  function automatic logic [LG2_W-1:0] lg2_entry(input u64_t x0);
    u64_t x;
    logic [LG2_W-1:0] res;
    x   = x0;
    res = '0;
    for (int b = 29; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (Q30_ONE << 1)) begin
        x      = x >> 1;
        res[b] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/local_magnitude_from_amplitude_core.sv
// Local magnitude from a zero-to-peak amplitude, distance and SNR. One word is taken per
// clock while in_tready is high; results pass through a 16-stage pipeline (a nine-stage
// log10 unit running beside a two-stage distance front end and four three-stage Horner
// steps, then two stages of combine, round and saturate) and then the output register. A
// two-entry output buffer lets the input keep flowing while a result waits, and in_tready
// drops only after two results are held. The distance factor and SNR threshold registers
// may be written only while no words are in flight.
`default_nettype none

`include "local_magnitude_from_amplitude_core_defines.svh"

module local_magnitude_from_amplitude_core
  import lmfa_pkg::*;
#(
  parameter int unsigned LOG_TABLE_ENTRIES = LOG_TAB_ENTRIES_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // amp_mm[43:0], dist_deg[67:44], snr_in[91:68]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // magnitude[21:0]
  output logic [OUT_USER_W-1:0] out_tuser   // status[1:0], treat_as_valid[2]
);

  localparam int LG_DLY = 5;
  localparam int RND_SH = 14;

  logic adv;

  logic [CFG_W-1:0] min_snr_r, km_per_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_snr_r    <= MIN_SNR_RST;
      km_per_deg_r <= KM_PER_DEG_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_MIN_SNR:    min_snr_r    <= cfg_wdata;
        REG_KM_PER_DEG: km_per_deg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [AMP_W-1:0] amp_in;
  logic [DEG_W-1:0] deg_in;
  logic [SNR_W-1:0] snr_in;

  assign amp_in = in_tdata[AMP_W-1:0];
  assign deg_in = in_tdata[AMP_W+DEG_W-1:AMP_W];
  assign snr_in = in_tdata[AMP_W+DEG_W+SNR_W-1:AMP_W+DEG_W];

  // Valid bits and per-word flags ride along the whole pipeline.
  logic [PIPE_DEPTH-1:0] vld_r;
  side_t                 side_r [PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].amp_zero <= (amp_in == '0);
      side_r[0].snr_low  <= (snr_in < min_snr_r);
      for (int i = 1; i < PIPE_DEPTH - 1; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  logic signed [LG_W-1:0] lg_w;

  lmfa_log #(
    .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
  ) u_log (
    .clk  (clk),
    .en   (adv),
    .amp_i(amp_in),
    .lg_o (lg_w)
  );

  // Distance front end: km in Q.32, then pick the range and scale the variable.
  logic [PKM_W-1:0] pkm_r;
  poly_t            dist_r, dist_nxt;
  logic [PKM_W-1:0] u_sum, w_sum;

  assign u_sum = pkm_r + PKM_W'(1 << 15);
  assign w_sum = pkm_r + PKM_W'(1 << 23);

  always_comb begin
    dist_nxt.is_near = (pkm_r <= NEAR_LIMIT);
    dist_nxt.x       = dist_nxt.is_near ? u_sum[X_W+15:16] : w_sum[X_W+23:24];
    dist_nxt.acc     = dist_nxt.is_near ? ACC0_NEAR : ACC0_FAR;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pkm_r  <= PKM_W'(deg_in) * PKM_W'(km_per_deg_r);
      dist_r <= dist_nxt;
    end
  end

  poly_t poly_w [5];

  assign poly_w[0] = dist_r;

  for (genvar k = 0; k < 4; k++) begin : g_step
    lmfa_horner u_step (
      .clk   (clk),
      .en    (adv),
      .c_near(C_NEAR[k]),
      .c_far (C_FAR[k]),
      .far_on(FAR_ON[k]),
      .poly_i(poly_w[k]),
      .poly_o(poly_w[k+1])
    );
  end

  // The log result is ready five stages before the distance correction.
  logic signed [LG_W-1:0] lg_dly_r [LG_DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      lg_dly_r[0] <= lg_w;
      for (int i = 1; i < LG_DLY; i++) begin
        lg_dly_r[i] <= lg_dly_r[i-1];
      end
    end
  end

  logic signed [TOT_W-1:0] tot_r, tot_nxt;
  logic signed [TOT_W-1:0] tot_bias, tot_b, q;
  logic                    q_fits;
  res_t                    res_r, res_nxt;

  always_comb begin
    if (poly_w[4].is_near) begin
      tot_nxt = TOT_W'(lg_dly_r[LG_DLY-1]) - TOT_W'(poly_w[4].acc);
    end else begin
      tot_nxt = TOT_W'(lg_dly_r[LG_DLY-1]) + (TOT_W'(poly_w[4].acc) <<< 6);
    end
  end

  always_comb begin
    tot_bias = tot_r[TOT_W-1] ? TOT_W'((1 << (RND_SH - 1)) - 1) : TOT_W'(1 << (RND_SH - 1));
    tot_b    = tot_r + tot_bias;
    q        = tot_b >>> RND_SH;
    q_fits   = (&q[TOT_W-1:MAG_W-1]) || !(|q[TOT_W-1:MAG_W-1]);
    res_nxt.treat_as_valid = 1'b0;
    res_nxt.status         = ST_OK;
    if (q_fits) begin
      res_nxt.magnitude = q[MAG_W-1:0];
    end else if (q[TOT_W-1]) begin
      res_nxt.magnitude = {1'b1, {(MAG_W-1){1'b0}}};
    end else begin
      res_nxt.magnitude = {1'b0, {(MAG_W-1){1'b1}}};
    end
    if (side_r[PIPE_DEPTH-2].amp_zero) begin
      res_nxt.magnitude = '0;
      res_nxt.status    = ST_AMP_RANGE;
    end else if (side_r[PIPE_DEPTH-2].snr_low) begin
      res_nxt.status         = ST_SNR_LOW;
      res_nxt.treat_as_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tot_r <= tot_nxt;
      res_r <= res_nxt;
    end
  end

  res_t out_res;

  lmfa_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vld_r[PIPE_DEPTH-1]),
    .in_res   (res_r),
    .adv      (adv),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign in_tready = adv;
  assign out_tdata = OUT_DATA_W'(out_res.magnitude);
  assign out_tuser = {out_res.treat_as_valid, out_res.status};

  // The input stalls only when both buffer entries hold results.
  `LMFA_ASSERT_SAME(a_stall_has_result, clk, rst_n, !in_tready, out_tvalid,
                    "input stalled with no result on the output")
  `LMFA_ASSERT_NEXT(a_stall_persists, clk, rst_n, !in_tready && !out_tready, !in_tready,
                    "buffer drained while the output was blocked")
  `LMFA_ASSERT_SAME(a_amp_zero_mag, clk, rst_n,
                    out_tvalid && (out_tuser[1:0] == ST_AMP_RANGE),
                    (out_tdata == '0) && !out_tuser[2],
                    "invalid amplitude result carries a magnitude")
  `LMFA_ASSERT_SAME(a_treat_matches, clk, rst_n, out_tvalid,
                    out_tuser[2] == (out_tuser[1:0] == ST_SNR_LOW),
                    "treat_as_valid disagrees with status")

endmodule

`default_nettype wire

// File: hw/rtl/lmfa_log.sv
`default_nettype none

module lmfa_log
  import lmfa_pkg::*;
#(
  parameter int unsigned LOG_TABLE_ENTRIES = LOG_TAB_ENTRIES_DFLT
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [AMP_W-1:0]       amp_i,
  output logic signed [LG_W-1:0] lg_o
);

  localparam int TW      = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int PROD_W  = FRAC_W + TW;
  localparam int REM_W   = 16;
  localparam int DPROD_W = LG2_W + REM_W;
  localparam int SPLIT_W = 20;
  localparam int KH_W    = L2_W - SPLIT_W;
  localparam int PPL_W   = SPLIT_W + LOG10_2_W;
  localparam int PPH_W   = KH_W + LOG10_2_W + 1;
  localparam int V_W     = PPH_W + SPLIT_W;
  localparam int LG_SH   = 28;
  localparam int EXP_W   = L2_W - 30;

  // log2 table, one entry past the end so the interpolation always has a right neighbor.
  logic [LG2_W-1:0] tab [LOG_TABLE_ENTRIES + 1];

  for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_tab
    if (g == LOG_TABLE_ENTRIES) begin : g_last
      assign tab[g] = LG2_ONE;
    end else begin : g_ent
      localparam u64_t X0 = Q30_ONE + ((u64_t'(g) << 30) / LOG_TABLE_ENTRIES);
      assign tab[g] = lg2_entry(X0);
    end
  end

  logic [AMP_W-1:0]         amp1_r;
  logic [LEAD_W-1:0]        lead1_r, lead2_r, lead3_r, lead4_r, lead5_r;
  logic [FRAC_W-1:0]        frac2_r;
  logic [TW-1:0]            idx3_r;
  logic [REM_W-1:0]         rem3_r, rem4_r;
  logic [LG2_W-1:0]         lo4_r, diff4_r, lo5_r;
  logic [DPROD_W-1:0]       dprod5_r;
  logic signed [L2_W-1:0]   l2_6_r;
  logic [PPL_W-1:0]         pplo7_r;
  logic signed [PPH_W-1:0]  pphi7_r;
  logic signed [V_W-1:0]    v8_r;
  logic signed [LG_W-1:0]   lg9_r;

  logic [LEAD_W-1:0]        lead1_nxt;
  logic [AMP_W-1:0]         shl;
  logic [PROD_W-1:0]        prod;
  logic [TW-1:0]            idx_hi;
  logic [LG2_W-1:0]         lo_rd, hi_rd, l2f;
  logic [EXP_W-1:0]         expo;
  logic signed [V_W-1:0]    bias8, v8_b, lg_full;

  always_comb begin
    lead1_nxt = '0;
    for (int i = 0; i < AMP_W; i++) begin
      if (amp_i[i]) begin
        lead1_nxt = LEAD_W'(i);
      end
    end
  end

  // Normalize so the leading one drops out and the fraction fills 43 bits.
  assign shl    = amp1_r << (LEAD_W'(FRAC_W) - lead1_r);
  assign prod   = PROD_W'(frac2_r) * PROD_W'(LOG_TABLE_ENTRIES);
  assign idx_hi = idx3_r + TW'(1);
  assign lo_rd  = tab[idx3_r];
  assign hi_rd  = tab[idx_hi];
  assign l2f    = lo5_r + dprod5_r[DPROD_W-1:REM_W];
  assign expo   = EXP_W'(lead5_r) - EXP_W'(24);

  always_comb begin
    bias8   = v8_r[V_W-1] ? V_W'((1 << (LG_SH - 1)) - 1) : V_W'(1 << (LG_SH - 1));
    v8_b    = v8_r + bias8;
    lg_full = v8_b >>> LG_SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amp1_r   <= amp_i;
      lead1_r  <= lead1_nxt;
      frac2_r  <= shl[FRAC_W-1:0];
      lead2_r  <= lead1_r;
      idx3_r   <= prod[PROD_W-1:FRAC_W];
      rem3_r   <= prod[FRAC_W-1:FRAC_W-REM_W];
      lead3_r  <= lead2_r;
      lo4_r    <= lo_rd;
      diff4_r  <= hi_rd - lo_rd;
      rem4_r   <= rem3_r;
      lead4_r  <= lead3_r;
      dprod5_r <= DPROD_W'(diff4_r) * DPROD_W'(rem4_r);
      lo5_r    <= lo4_r;
      lead5_r  <= lead4_r;
      l2_6_r   <= {expo, l2f[29:0]};
      pplo7_r  <= PPL_W'(l2_6_r[SPLIT_W-1:0]) * PPL_W'(LOG10_2_Q28);
      pphi7_r  <= PPH_W'($signed(l2_6_r[L2_W-1:SPLIT_W]))
                  * $signed(PPH_W'({1'b0, LOG10_2_Q28}));
      v8_r     <= (V_W'(pphi7_r) <<< SPLIT_W) + $signed(V_W'(pplo7_r));
      lg9_r    <= lg_full[LG_W-1:0];
    end
  end

  assign lg_o = lg9_r;

endmodule

`default_nettype wire

// File: hw/rtl/lmfa_horner.sv
`default_nettype none

module lmfa_horner
  import lmfa_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ACC_W-1:0] c_near,
  input  logic signed [ACC_W-1:0] c_far,
  input  logic                    far_on,
  input  poly_t                   poly_i,
  output poly_t                   poly_o
);

  localparam int LO_W  = 21;
  localparam int HI_W  = ACC_W - LO_W;
  localparam int PPL_W = LO_W + X_W;
  localparam int PPH_W = HI_W + X_W + 1;
  localparam int V_W   = PPH_W + LO_W;
  localparam int SH    = 24;

  poly_t                   m_r, s_r, r_r;
  logic [PPL_W-1:0]        pplo_r;
  logic signed [PPH_W-1:0] pphi_r;
  logic signed [V_W-1:0]   v_r;

  logic signed [V_W-1:0]   bias, v_b, q;
  logic                    apply;
  poly_t                   r_nxt;

  always_comb begin
    bias  = v_r[V_W-1] ? V_W'((1 << (SH - 1)) - 1) : V_W'(1 << (SH - 1));
    v_b   = v_r + bias;
    q     = v_b >>> SH;
    apply = s_r.is_near || far_on;
    r_nxt = s_r;
    if (apply) begin
      r_nxt.acc = q[ACC_W-1:0] + (s_r.is_near ? c_near : c_far);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Split the accumulator so each product stays a narrow multiply.
      pplo_r <= PPL_W'(poly_i.acc[LO_W-1:0]) * PPL_W'(poly_i.x);
      pphi_r <= PPH_W'($signed(poly_i.acc[ACC_W-1:LO_W]))
                * $signed(PPH_W'({1'b0, poly_i.x}));
      m_r    <= poly_i;
      v_r    <= (V_W'(pphi_r) <<< LO_W) + $signed(V_W'(pplo_r));
      s_r    <= m_r;
      r_r    <= r_nxt;
    end
  end

  assign poly_o = r_r;

endmodule

`default_nettype wire

// File: hw/rtl/lmfa_outbuf.sv
`default_nettype none

module lmfa_outbuf
  import lmfa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  res_t in_res,
  output logic adv,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic o_valid_r, o_valid_nxt;
  logic s_valid_r, s_valid_nxt;
  res_t o_res_r, s_res_r;
  logic take, o_free, o_from_s, o_from_in, s_load;

  // The pipeline moves only while the spare entry is empty.
  assign adv    = !s_valid_r;
  assign take   = in_valid && adv;
  assign o_free = !o_valid_r || out_ready;

  always_comb begin
    o_valid_nxt = o_valid_r;
    s_valid_nxt = s_valid_r;
    o_from_s    = 1'b0;
    o_from_in   = 1'b0;
    s_load      = 1'b0;
    if (o_free) begin
      if (s_valid_r) begin
        o_from_s    = 1'b1;
        o_valid_nxt = 1'b1;
        s_valid_nxt = 1'b0;
      end else begin
        o_from_in   = take;
        o_valid_nxt = take;
      end
    end else if (take) begin
      s_load      = 1'b1;
      s_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (o_from_s) begin
      o_res_r <= s_res_r;
    end else if (o_from_in) begin
      o_res_r <= in_res;
    end
    if (s_load) begin
      s_res_r <= in_res;
    end
  end

  assign out_valid = o_valid_r;
  assign out_res   = o_res_r;

endmodule

`default_nettype wire
